// File: rtl/cosine_palette_color_generator_macros.svh
// Assertion macros for the cosine palette RTL.
`ifndef COSINE_PALETTE_COLOR_GENERATOR_MACROS_SVH
`define COSINE_PALETTE_COLOR_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CPCG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CPCG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cpcg_pkg.sv
// Types, constants and cosine table builder for the cosine palette generator.
package cpcg_pkg;

  localparam int COEF_W      = 16;   // signed Q3.12 coefficient
  localparam int FRAC_BITS   = 12;
  localparam int REG_W       = 48;   // three packed coefficients
  localparam int CFG_INDEX_W = 4;
  localparam int ANGLE_BITS  = 10;   // cosine table resolution, bits per turn
  localparam int QUARTER     = 2 ** (ANGLE_BITS - 2);
  localparam int ADDR_W      = ANGLE_BITS - 1;  // holds 0..QUARTER
  localparam int COS_W       = 14;   // signed Q1.12, -4096..4096
  localparam int VAL_W       = 30;   // bias*4096 + amplitude*cosine
  localparam int VAL_FRAC    = 2 * FRAC_BITS;

  localparam logic [REG_W-1:0] BIAS_RESET      = 48'h0800_0800_0800;
  localparam logic [REG_W-1:0] AMPLITUDE_RESET = 48'h0800_0800_0800;
  localparam logic [REG_W-1:0] FREQUENCY_RESET = 48'h1000_1000_1000;
  localparam logic [REG_W-1:0] PHASE_RESET     = 48'h0000_0000_0000;

  localparam longint TWO_PI_Q30 = 64'd6746518852;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BIAS      = 4'd0,
    CFG_AMPLITUDE = 4'd1,
    CFG_FREQUENCY = 4'd2,
    CFG_PHASE     = 4'd3
  } cfg_reg_t;

  // per-stage load strobes from the pipeline control
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_en_t;

  // Cosine of m/2^ANGLE_BITS turns, m in 0..QUARTER, from a 7-term Taylor
  // series in Q30. Evaluated only at elaboration to build constant tables.
  function automatic logic signed [COS_W-1:0] quarter_cos(input int unsigned m);
    longint x;
    longint x2;
    longint term;
    longint s;
    x    = (longint'(m) * TWO_PI_Q30 + (64'sd1 <<< (ANGLE_BITS - 1))) >>> ANGLE_BITS;
    x2   = (x * x) >>> 30;
    term = 64'sd1 <<< 30;
    s    = term;
    term = ((term * x2) >>> 30) / 2;   s = s - term;
    term = ((term * x2) >>> 30) / 12;  s = s + term;
    term = ((term * x2) >>> 30) / 30;  s = s - term;
    term = ((term * x2) >>> 30) / 56;  s = s + term;
    term = ((term * x2) >>> 30) / 90;  s = s - term;
    term = ((term * x2) >>> 30) / 132; s = s + term;
    term = ((term * x2) >>> 30) / 182; s = s - term;
    if (s < 0) begin
      s = 0;
    end
    return COS_W'((s + (64'sd1 <<< 17)) >>> 18);
  endfunction

endpackage

// File: rtl/cpcg_lane.sv
// One color channel of the cosine palette datapath, four register stages.
module cpcg_lane #(
  parameter int POSITION_BITS = 16,
  parameter int COLOUR_BITS   = 8
) (
  input  logic                                  clk,
  input  cpcg_pkg::stage_en_t                   en,
  input  logic [POSITION_BITS-1:0]              t_position,
  input  logic signed [cpcg_pkg::COEF_W-1:0]    coef_bias,
  input  logic signed [cpcg_pkg::COEF_W-1:0]    coef_amp,
  input  logic signed [cpcg_pkg::COEF_W-1:0]    coef_freq,
  input  logic signed [cpcg_pkg::COEF_W-1:0]    coef_phase,
  output logic [COLOUR_BITS-1:0]                colour
);

  localparam int MUL_W   = cpcg_pkg::COEF_W + POSITION_BITS + 1;
  localparam int ANG_W   = cpcg_pkg::FRAC_BITS + POSITION_BITS;
  localparam int A_BITS  = cpcg_pkg::ANGLE_BITS;
  localparam int AD_W    = cpcg_pkg::ADDR_W;
  localparam int VAL_W   = cpcg_pkg::VAL_W;
  localparam int VF      = cpcg_pkg::VAL_FRAC;
  localparam int SCALE_W = VF + COLOUR_BITS;
  localparam logic [COLOUR_BITS-1:0] MAXC = '1;

  // constant quarter-wave table, one entry past the quarter
  logic signed [cpcg_pkg::COS_W-1:0] cos_tab [0:cpcg_pkg::QUARTER];
  for (genvar g = 0; g <= cpcg_pkg::QUARTER; g++) begin : g_tab
    assign cos_tab[g] = cpcg_pkg::quarter_cos(g);
  end

  // stage 1: angle in turns, keep the table index
  logic signed [MUL_W-1:0] mul_angle;
  logic [ANG_W-1:0]        angle_sum;
  logic [A_BITS-1:0]       k_nxt, k_r;

  assign mul_angle = coef_freq * signed'({1'b0, t_position});
  assign angle_sum = mul_angle[ANG_W-1:0]
                   + {coef_phase[cpcg_pkg::FRAC_BITS-1:0], {POSITION_BITS{1'b0}}};
  assign k_nxt     = angle_sum[ANG_W-1 -: A_BITS];

  always_ff @(posedge clk) begin
    if (en.ld1) begin
      k_r <= k_nxt;
    end
  end

  // stage 2: quadrant fold and table read
  logic [1:0]                        quad;
  logic [A_BITS-3:0]                 rem;
  logic [AD_W-1:0]                   addr;
  logic signed [cpcg_pkg::COS_W-1:0] mag;
  logic signed [cpcg_pkg::COS_W-1:0] cos_nxt, cos_r;

  assign quad = k_r[A_BITS-1 -: 2];
  assign rem  = k_r[A_BITS-3:0];
  assign addr = quad[0] ? (AD_W'(cpcg_pkg::QUARTER) - {1'b0, rem}) : {1'b0, rem};
  assign mag  = cos_tab[addr];
  assign cos_nxt = (quad[1] ^ quad[0]) ? -mag : mag;

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      cos_r <= cos_nxt;
    end
  end

  // stage 3: bias + amplitude * cosine, Q.24
  logic signed [VAL_W-1:0] bias_term, amp_term, value_nxt, value_r;

  assign bias_term = VAL_W'(coef_bias) <<< cpcg_pkg::FRAC_BITS;
  assign amp_term  = coef_amp * cos_r;
  assign value_nxt = bias_term + amp_term;

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      value_r <= value_nxt;
    end
  end

  // stage 4: clamp to [0,1] and scale with rounding
  logic [SCALE_W-1:0]     scaled;
  logic [COLOUR_BITS-1:0] colour_nxt, colour_r;

  assign scaled = SCALE_W'(value_r[VF-1:0]) * SCALE_W'(MAXC)
                + (SCALE_W'(1) << (VF - 1));

  always_comb begin
    if (value_r[VAL_W-1] || (value_r == '0)) begin
      colour_nxt = '0;
    end else if (value_r[VAL_W-2:VF] != '0) begin
      colour_nxt = MAXC;
    end else begin
      colour_nxt = scaled[SCALE_W-1 -: COLOUR_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld4) begin
      colour_r <= colour_nxt;
    end
  end

  assign colour = colour_r;

endmodule

// File: rtl/cosine_palette_color_generator.sv
// Cosine palette color generator: gradient position to RGB, four-stage pipeline.
//
// Each position t on in_t_position (unsigned Q0.POSITION_BITS) produces one
// RGB transaction where every channel is bias + amplitude*cos(2*pi*(freq*t +
// phase)), clamped to [0,1] and scaled to COLOUR_BITS. Coefficients are
// signed Q3.12, three per 48-bit register (red 15:0, green 31:16, blue
// 47:32), written through the cfg_ port: index 0 bias, 1 amplitude,
// 2 frequency, 3 phase; other indexes are dropped. cfg_ready is always high.
// Write registers only while no transaction is in flight.
// Throughput is one transaction per clock while out_stall is low. Stages:
// angle multiply, quarter-wave cosine table read (built at elaboration,
// 2^ANGLE_BITS steps per turn), amplitude multiply-add, clamp/scale into
// the output register. Each stage holds its own valid bit, so bubbles
// collapse while the output is stalled and in_stall rises only when all
// four stages hold a transaction.
module cosine_palette_color_generator #(
  parameter int POSITION_BITS = 16,
  parameter int COLOUR_BITS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [POSITION_BITS-1:0]             in_t_position,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [COLOUR_BITS-1:0]               out_red,
  output logic [COLOUR_BITS-1:0]               out_green,
  output logic [COLOUR_BITS-1:0]               out_blue,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cpcg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cpcg_pkg::REG_W-1:0]           cfg_data
);

  localparam int CW = cpcg_pkg::COEF_W;

  // coefficient registers
  logic [cpcg_pkg::REG_W-1:0] bias_r, amp_r, freq_r, phase_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r  <= cpcg_pkg::BIAS_RESET;
      amp_r   <= cpcg_pkg::AMPLITUDE_RESET;
      freq_r  <= cpcg_pkg::FREQUENCY_RESET;
      phase_r <= cpcg_pkg::PHASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cpcg_pkg::cfg_reg_t'(cfg_index))
        cpcg_pkg::CFG_BIAS:      bias_r  <= cfg_data;
        cpcg_pkg::CFG_AMPLITUDE: amp_r   <= cfg_data;
        cpcg_pkg::CFG_FREQUENCY: freq_r  <= cfg_data;
        cpcg_pkg::CFG_PHASE:     phase_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control: vld_r[0] is stage 1, vld_r[3] the output register
  logic [3:0]          vld_r, vld_nxt;
  logic [3:0]          ready;
  cpcg_pkg::stage_en_t en;

  always_comb begin
    ready[3] = !vld_r[3] || !out_stall;
    ready[2] = !vld_r[2] || ready[3];
    ready[1] = !vld_r[1] || ready[2];
    ready[0] = !vld_r[0] || ready[1];
  end

  assign in_stall = !ready[0];
  assign out_valid = vld_r[3];

  assign en.ld1 = ready[0] && in_valid;
  assign en.ld2 = ready[1] && vld_r[0];
  assign en.ld3 = ready[2] && vld_r[1];
  assign en.ld4 = ready[3] && vld_r[2];

  always_comb begin
    vld_nxt = vld_r;
    if (ready[0]) vld_nxt[0] = in_valid;
    if (ready[1]) vld_nxt[1] = vld_r[0];
    if (ready[2]) vld_nxt[2] = vld_r[1];
    if (ready[3]) vld_nxt[3] = vld_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // three channel datapaths
  logic [COLOUR_BITS-1:0] colour [0:2];

  for (genvar ch = 0; ch < 3; ch++) begin : g_lane
    cpcg_lane #(
      .POSITION_BITS (POSITION_BITS),
      .COLOUR_BITS   (COLOUR_BITS)
    ) u_lane (
      .clk        (clk),
      .en         (en),
      .t_position (in_t_position),
      .coef_bias  (signed'(bias_r[CW*ch +: CW])),
      .coef_amp   (signed'(amp_r[CW*ch +: CW])),
      .coef_freq  (signed'(freq_r[CW*ch +: CW])),
      .coef_phase (signed'(phase_r[CW*ch +: CW])),
      .colour     (colour[ch])
    );
  end

  assign out_red   = colour[0];
  assign out_green = colour[1];
  assign out_blue  = colour[2];

  // checks
`include "cosine_palette_color_generator_macros.svh"

  `CPCG_ASSERT_NOW(a_stall_only_full, clk, rst_n, in_stall,
    (vld_r == 4'b1111) && out_stall, "input stalled with a free pipeline stage")
  `CPCG_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && !in_stall,
    vld_r[0], "accepted transaction not held in stage 1")
  `CPCG_ASSERT_NEXT(a_s3_reaches_out, clk, rst_n, vld_r[2] && (!vld_r[3] || !out_stall),
    out_valid, "stage 3 transaction did not reach the output")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the cosine palette color generator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration, taken from the package where it exists there.
  localparam int POSITION_BITS = 16;
  localparam int COLOUR_BITS   = 8;
  localparam int ANGLE_BITS    = cpcg_pkg::ANGLE_BITS;
  localparam int FRAC_BITS     = cpcg_pkg::FRAC_BITS;
  localparam int REG_W         = cpcg_pkg::REG_W;
  localparam int INDEX_W       = cpcg_pkg::CFG_INDEX_W;
  localparam int LANE_W        = cpcg_pkg::COEF_W;

  // Table index = angle bits just below the binary point of the turn count.
  localparam int ANGLE_LSB  = FRAC_BITS + POSITION_BITS - ANGLE_BITS;
  localparam int TURN_STEPS = 2 ** ANGLE_BITS;
  localparam int QUAD_STEPS = TURN_STEPS / 4;

  // 2*pi in Q30, used by the Taylor series of the quarter-wave cosine.
  localparam longint unsigned TWO_PI_FIX = 64'd6746518852;

  // Register indexes beyond the last real register must be dropped.
  localparam int STRAY_LOW  = int'(cpcg_pkg::CFG_PHASE) + 1;
  localparam int STRAY_HIGH = 2 ** INDEX_W - 1;

  localparam int PIPE_DEPTH = 4;            // accept to out_valid
  localparam int HALF_CYCLE = 5;
  localparam longint RUN_LIMIT_NS = 5_000_000;

  typedef logic [LANE_W-1:0]      lane_t;
  typedef logic [REG_W-1:0]       coef_reg_t;
  typedef logic [COLOUR_BITS-1:0] shade_t;

  typedef struct {
    logic [POSITION_BITS-1:0] position;
    shade_t red;
    shade_t green;
    shade_t blue;
  } color_t;

  // Scoreboard: keeps its own copy of the coefficient registers and the
  // cosine table, predicts the color for each accepted position and
  // compares results against the oldest prediction.
  class palette_scoreboard;
    coef_reg_t bias;
    coef_reg_t amplitude;
    coef_reg_t frequency;
    coef_reg_t phase;
    longint    cos_turn [TURN_STEPS];
    color_t    pending [$];
    int        errors;

    function new();
      bias      = cpcg_pkg::BIAS_RESET;
      amplitude = cpcg_pkg::AMPLITUDE_RESET;
      frequency = cpcg_pkg::FREQUENCY_RESET;
      phase     = cpcg_pkg::PHASE_RESET;
      errors    = 0;
      for (int k = 0; k < TURN_STEPS; k++) begin
        case (k / QUAD_STEPS)
          0: cos_turn[k] = taylor_cos(k % QUAD_STEPS);
          1: cos_turn[k] = -taylor_cos(QUAD_STEPS - k % QUAD_STEPS);
          2: cos_turn[k] = -taylor_cos(k % QUAD_STEPS);
          default: cos_turn[k] = taylor_cos(QUAD_STEPS - k % QUAD_STEPS);
        endcase
      end
    endfunction

    // cos(2*pi*m/TURN_STEPS) in Q1.12, seven Taylor terms in Q30
    function longint taylor_cos(int unsigned m);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      x    = m;
      x    = (x * TWO_PI_FIX + (64'd1 << (ANGLE_BITS - 1))) >> ANGLE_BITS;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(term);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      return (sum + (64'sd1 <<< 17)) >>> 18;
    endfunction

    function void write_reg(logic [INDEX_W-1:0] index, coef_reg_t data);
      case (index)
        cpcg_pkg::CFG_BIAS:      bias      = data;
        cpcg_pkg::CFG_AMPLITUDE: amplitude = data;
        cpcg_pkg::CFG_FREQUENCY: frequency = data;
        cpcg_pkg::CFG_PHASE:     phase     = data;
        default: ;                           // unknown index is dropped
      endcase
    endfunction

    function shade_t shade(int ch, logic [POSITION_BITS-1:0] t);
      logic signed [LANE_W-1:0] a;
      logic signed [LANE_W-1:0] b;
      logic signed [LANE_W-1:0] c;
      logic signed [LANE_W-1:0] d;
      longint                   angle;
      logic [ANGLE_BITS-1:0]    k;
      longint                   value;
      longint                   top;
      a     = bias[LANE_W*ch +: LANE_W];
      b     = amplitude[LANE_W*ch +: LANE_W];
      c     = frequency[LANE_W*ch +: LANE_W];
      d     = phase[LANE_W*ch +: LANE_W];
      top   = (64'sd1 <<< COLOUR_BITS) - 1;
      // negative angles wrap through two's complement truncation
      angle = longint'(c) * longint'(t) + longint'(d) * (64'sd1 <<< POSITION_BITS);
      k     = angle[ANGLE_LSB +: ANGLE_BITS];
      value = longint'(a) * (64'sd1 <<< FRAC_BITS) + longint'(b) * cos_turn[k];
      if (value <= 0) begin
        return '0;
      end
      if (value >= (64'sd1 <<< (2 * FRAC_BITS))) begin
        return shade_t'(top);
      end
      return shade_t'((value * top + (64'sd1 <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS));
    endfunction

    function void note_position(logic [POSITION_BITS-1:0] t);
      color_t c;
      c.position = t;
      c.red      = shade(0, t);
      c.green    = shade(1, t);
      c.blue     = shade(2, t);
      pending.push_back(c);
    endfunction

    function void check_color(shade_t red, shade_t green, shade_t blue);
      color_t c;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected color transaction r=%0d g=%0d b=%0d", red, green, blue);
        end
        return;
      end
      c = pending.pop_front();
      if (c.red !== red || c.green !== green || c.blue !== blue) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch t=%h: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   c.position, c.red, c.green, c.blue, red, green, blue);
        end
      end
    endfunction

    // predictions never matched count as failures too
    function int failures();
      return errors + pending.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [POSITION_BITS-1:0] in_t_position;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  shade_t                   out_red;
  shade_t                   out_green;
  shade_t                   out_blue;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [INDEX_W-1:0]       cfg_index;
  coef_reg_t                cfg_data;

  palette_scoreboard sb = new();

  // Positions that hit the table edges at the reset setting (frequency 1.0
  // turns one table step per 2^6 of t): zero, the top, quadrant boundaries
  // and their neighbors, one step, alternating bit patterns.
  localparam logic [POSITION_BITS-1:0] CORNER_T [14] = '{
    16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h0001, 16'h3FFF,
    16'h7FFF, 16'hBFFF, 16'h0040, 16'h003F, 16'hAAAA, 16'h5555, 16'h2000
  };

  cosine_palette_color_generator #(
    .POSITION_BITS(POSITION_BITS),
    .COLOUR_BITS  (COLOUR_BITS)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_t_position(in_t_position),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #(HALF_CYCLE) clk = 1'b1;
    #(HALF_CYCLE) clk = 1'b0;
  end

  // Result side: check every accepted transaction, then pick the next
  // stall value. Stall behavior switches at random between modes: free
  // running, light, medium and heavy back-pressure.
  int stall_mode = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_color(out_red, out_green, out_blue);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Offer one position and hold it until the block takes it. valid is
  // left high so back-to-back calls stream without a bubble.
  task automatic send_position(logic [POSITION_BITS-1:0] t);
    in_valid      <= 1'b1;
    in_t_position <= t;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    sb.note_position(t);
  endtask

  // Sender gap; payload wanders while valid is low.
  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      in_valid      <= 1'b0;
      in_t_position <= POSITION_BITS'($urandom);
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Wait for every predicted color, then let the pipe empty out.
  task automatic wait_drained();
    while (sb.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // One register write transaction; valid stays up for back-to-back writes,
  // the caller drops it after the last one.
  task automatic cfg_write(logic [INDEX_W-1:0] index, coef_reg_t data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    sb.write_reg(index, data);
  endtask

  // Load a full coefficient set while idle. A write to a nonexistent
  // register is slipped in between to prove it is ignored.
  task automatic load_palette(coef_reg_t b, coef_reg_t a, coef_reg_t f, coef_reg_t p);
    wait_drained();
    cfg_write(cpcg_pkg::CFG_BIAS, b);
    cfg_write(INDEX_W'($urandom_range(STRAY_LOW, STRAY_HIGH)),
              coef_reg_t'({$urandom, $urandom}));
    cfg_write(cpcg_pkg::CFG_AMPLITUDE, a);
    cfg_write(cpcg_pkg::CFG_FREQUENCY, f);
    cfg_write(cpcg_pkg::CFG_PHASE, p);
    cfg_valid <= 1'b0;
  endtask

  function automatic coef_reg_t splat(lane_t v);
    return {v, v, v};
  endfunction

  // Mostly plausible palettes so colors land inside (0,1); one lane in
  // five takes any 16-bit pattern.
  function automatic coef_reg_t random_coef(cpcg_pkg::cfg_reg_t role);
    coef_reg_t r;
    lane_t     v;
    for (int ch = 0; ch < 3; ch++) begin
      if ($urandom_range(0, 4) == 0) begin
        v = lane_t'($urandom);
      end else begin
        case (role)
          cpcg_pkg::CFG_BIAS:      v = lane_t'($urandom_range(0, 4096));
          cpcg_pkg::CFG_AMPLITUDE: v = lane_t'($urandom_range(0, 8192)) - 16'd4096;
          cpcg_pkg::CFG_FREQUENCY: v = lane_t'($urandom_range(0, 32768)) - 16'd16384;
          default:                 v = lane_t'($urandom);
        endcase
      end
      r[LANE_W*ch +: LANE_W] = v;
    end
    return r;
  endfunction

  function automatic logic [POSITION_BITS-1:0] random_position();
    if ($urandom_range(0, 9) == 0) begin
      return CORNER_T[$urandom_range(0, 13)];
    end
    return POSITION_BITS'($urandom);
  endfunction

  // Random positions in bursts of random length with random gaps; a
  // quarter of the gaps are zero so long unbroken streams occur too.
  // With hold_mid the sender stops halfway until all colors are back.
  task automatic stream_positions(int count, bit hold_mid);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && left > 0; i++) begin
        send_position(random_position());
        left--;
        if (hold_mid && left == count / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_t_position <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset palette: corner positions back to back, no idling.
    foreach (CORNER_T[i]) begin
      send_position(CORNER_T[i]);
    end
    in_valid <= 1'b0;

    // Coefficient extremes: zero, most positive, most negative, minus one
    // LSB, and a mix that drives channels into both saturation limits.
    load_palette('0, '0, '0, '0);
    stream_positions(16, 1'b0);
    load_palette(splat(16'h7FFF), splat(16'h7FFF), splat(16'h7FFF), splat(16'h7FFF));
    stream_positions(16, 1'b0);
    load_palette(splat(16'h8000), splat(16'h8000), splat(16'h8000), splat(16'h8000));
    stream_positions(16, 1'b0);
    load_palette(splat(16'hFFFF), splat(16'hFFFF), splat(16'hFFFF), splat(16'hFFFF));
    stream_positions(16, 1'b0);
    load_palette({16'h0000, 16'h1000, 16'h0800}, {16'h7FFF, 16'h8000, 16'h1000},
                 {16'h8000, 16'h7FFF, 16'hF000}, {16'h7FFF, 16'h8000, 16'h0400});
    stream_positions(16, 1'b0);

    // Random palettes with negative frequencies and phases mixed in.
    for (int phase_no = 0; phase_no < 10; phase_no++) begin
      load_palette(random_coef(cpcg_pkg::CFG_BIAS),
                   random_coef(cpcg_pkg::CFG_AMPLITUDE),
                   random_coef(cpcg_pkg::CFG_FREQUENCY),
                   random_coef(cpcg_pkg::CFG_PHASE));
      stream_positions(72, phase_no == 3);
    end

    // Back to the power-on palette for a final stretch.
    load_palette(cpcg_pkg::BIAS_RESET, cpcg_pkg::AMPLITUDE_RESET,
                 cpcg_pkg::FREQUENCY_RESET, cpcg_pkg::PHASE_RESET);
    stream_positions(40, 1'b0);

    wait_drained();
    if (sb.failures() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench failed");
    $finish;
  end

endmodule
